@@ sv/lsad_pkg.sv @@
// Package for the load/store address and data unit.
// Holds the item structs, decode codes and constants shared by all modules.
`timescale 1ns / 1ps

package lsad_pkg;

    // One input item.
    typedef struct packed {
        logic        req_type;
        logic [31:0] op_word;
        logic [31:0] base_value;
        logic [31:0] offset_reg_value;
        logic [31:0] shift_reg_value;
        logic [31:0] source_value;
        logic [31:0] mem_word;
        logic        carry_in;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [31:0] access_address;
        logic [1:0]  access_size;
        logic        is_store;
        logic [31:0] store_data;
        logic [31:0] load_value;
        logic        load_enable;
        logic [3:0]  dest_index;
        logic [3:0]  base_index;
        logic        base_writeback;
        logic [31:0] base_new;
        logic        reload_pipeline;
        logic        unsupported;
    } t_out_item;

    // Barrel shifter types, instruction bits 5-6 of the word/byte form.
    localparam logic [1:0] C_SHIFT_LSL = 2'b00;
    localparam logic [1:0] C_SHIFT_LSR = 2'b01;
    localparam logic [1:0] C_SHIFT_ASR = 2'b10;
    localparam logic [1:0] C_SHIFT_ROR = 2'b11;

    // Halfword-form sub-operations, instruction bits 5-6.
    localparam logic [1:0] C_HOP_SWP = 2'b00;
    localparam logic [1:0] C_HOP_UH  = 2'b01;
    localparam logic [1:0] C_HOP_SB  = 2'b10;
    localparam logic [1:0] C_HOP_SH  = 2'b11;

    // Access size codes.
    localparam logic [1:0] C_SIZE_BYTE = 2'd0;
    localparam logic [1:0] C_SIZE_HALF = 2'd1;
    localparam logic [1:0] C_SIZE_WORD = 2'd2;

    // Program counter register number and its read-ahead adjustment.
    localparam logic [3:0]  C_REG_PC = 4'hF;
    localparam logic [31:0] C_PC_ADJ = 32'd4;

endpackage

@@ sv/lsad_shifter.sv @@
// Barrel shifter for the register offset of word/byte transfers.
// Depends on lsad_pkg for the shift type codes.
`timescale 1ns / 1ps

module lsad_shifter (
    input  logic [31:0] i_value,
    input  logic [1:0]  i_type,
    input  logic [7:0]  i_amount,
    input  logic        i_by_reg,
    input  logic        i_carry,
    output logic [31:0] o_result
);
    import lsad_pkg::*;

    logic        w_big;
    logic [4:0]  w_n;
    logic [63:0] w_rot;
    logic [31:0] w_sign;

    assign w_big  = |i_amount[7:5];
    assign w_n    = i_amount[4:0];
    assign w_rot  = {i_value, i_value} >> w_n;
    assign w_sign = {32{i_value[31]}};

    always_comb begin
        o_result = i_value;
        if (!i_by_reg && (i_amount == 8'd0)) begin
            // An immediate amount of zero encodes the special forms.
            case (i_type)
                C_SHIFT_LSL: o_result = i_value;
                C_SHIFT_LSR: o_result = 32'd0;
                C_SHIFT_ASR: o_result = w_sign;
                default:     o_result = {i_carry, i_value[31:1]};
            endcase
        end else if (i_amount != 8'd0) begin
            case (i_type)
                C_SHIFT_LSL: o_result = w_big ? 32'd0 : (i_value << w_n);
                C_SHIFT_LSR: o_result = w_big ? 32'd0 : (i_value >> w_n);
                C_SHIFT_ASR: o_result = w_big ? w_sign : 32'($signed(i_value) >>> w_n);
                default:     o_result = w_rot[31:0];
            endcase
        end
    end

endmodule

@@ sv/lsad_load_format.sv @@
// Load data extraction: lane select, rotation and sign extension.
// Depends on lsad_pkg for the halfword sub-operation codes.
`timescale 1ns / 1ps

module lsad_load_format (
    input  logic        i_half_form,
    input  logic        i_is_byte,
    input  logic [1:0]  i_hop,
    input  logic [1:0]  i_addr_low,
    input  logic [31:0] i_mem_word,
    output logic [31:0] o_value
);
    import lsad_pkg::*;

    logic [63:0] w_rot;
    logic [7:0]  w_byte;
    logic [15:0] w_lane;

    assign w_rot  = {i_mem_word, i_mem_word} >> {i_addr_low, 3'b000};
    assign w_byte = w_rot[7:0];
    assign w_lane = i_addr_low[1] ? i_mem_word[31:16] : i_mem_word[15:0];

    always_comb begin
        o_value = 32'd0;
        if (!i_half_form) begin
            o_value = i_is_byte ? {24'd0, w_byte} : w_rot[31:0];
        end else begin
            case (i_hop)
                C_HOP_UH: o_value = i_addr_low[0] ? {w_lane[7:0], 16'd0, w_lane[15:8]}
                                                  : {16'd0, w_lane};
                C_HOP_SB: o_value = {{24{w_byte[7]}}, w_byte};
                C_HOP_SH: o_value = i_addr_low[0] ? {{24{w_lane[15]}}, w_lane[15:8]}
                                                  : {{16{w_lane[15]}}, w_lane};
                default:  o_value = 32'd0;
            endcase
        end
    end

endmodule

@@ sv/load_store_address_and_data_unit.sv @@
// Top level of the load/store address and data unit: a three-stage pipeline.
// Depends on lsad_pkg, lsad_shifter and lsad_load_format.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  -------------------------
//  in        to block   i_in_valid / o_in_stall   i_in_item  (t_in_item)
//  out       from block o_out_valid / i_out_stall o_out_item (t_out_item)
//
// The unit takes one item per cycle unless the output stalls.
// Stage 1 forms the offset through the barrel shifter, stage 2 does the 32-bit
// add or subtract that gives the address, and stage 3 formats load and store
// data into the output register. Each stage holds its own valid bit and moves
// whenever the stage after it is empty or moving, so bubbles close up and a
// stall on the output side backs up one stage at a time. Reset, synchronous
// and active low, clears only the valid bits.

module load_store_address_and_data_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lsad_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lsad_pkg::t_out_item o_out_item
);
    import lsad_pkg::*;

    // Stage 1 holds the decoded fields, the offset and the adjusted operands.
    typedef struct packed {
        logic        half_form;
        logic        load;
        logic        pre;
        logic        up;
        logic        wb_bit;
        logic        byte_bit;
        logic [1:0]  hop;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [31:0] base;
        logic [31:0] offset;
        logic [31:0] src;
        logic [31:0] mem;
    } t_s1;

    // Stage 2 replaces base and offset with the two addresses.
    typedef struct packed {
        logic        half_form;
        logic        load;
        logic        pre;
        logic        wb_bit;
        logic        byte_bit;
        logic [1:0]  hop;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [31:0] eff;
        logic [31:0] addr;
        logic [31:0] src;
        logic [31:0] mem;
    } t_s2;

    logic      r_v1, r_v2, r_v3;
    t_s1       r_s1, n_s1;
    t_s2       r_s2, n_s2;
    t_out_item r_out, n_out;

    logic en1, en2, en3;

    // A stage advances when its successor is empty or advancing itself.
    assign en3 = !r_v3 || !i_out_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_stall  = !en1;
    assign o_out_valid = r_v3;
    assign o_out_item  = r_out;

    // ---------------- Stage 1: offset formation ----------------
    logic [31:0] w_op;
    logic        w_by_reg;
    logic        w_reg_shift;
    logic [31:0] w_shift_in;
    logic [31:0] w_shifted;

    assign w_op        = i_in_item.op_word;
    assign w_by_reg    = w_op[4];
    // Register-specified shifts read the program counter one word further on.
    assign w_reg_shift = !i_in_item.req_type && w_op[25] && w_by_reg;
    assign w_shift_in  = (w_by_reg && (w_op[3:0] == C_REG_PC))
                         ? i_in_item.offset_reg_value + C_PC_ADJ
                         : i_in_item.offset_reg_value;

    lsad_shifter u_shifter (
        .i_value  (w_shift_in),
        .i_type   (w_op[6:5]),
        .i_amount (w_by_reg ? i_in_item.shift_reg_value[7:0] : {3'd0, w_op[11:7]}),
        .i_by_reg (w_by_reg),
        .i_carry  (i_in_item.carry_in),
        .o_result (w_shifted)
    );

    always_comb begin
        n_s1.half_form = i_in_item.req_type;
        n_s1.load      = w_op[20];
        n_s1.pre       = w_op[24];
        n_s1.up        = w_op[23];
        n_s1.wb_bit    = w_op[21];
        n_s1.byte_bit  = w_op[22];
        n_s1.hop       = w_op[6:5];
        n_s1.rd        = w_op[15:12];
        n_s1.rn        = w_op[19:16];
        n_s1.mem       = i_in_item.mem_word;
        // Stores of the program counter write its value plus one word.
        n_s1.src       = (w_op[15:12] == C_REG_PC) ? i_in_item.source_value + C_PC_ADJ
                                                   : i_in_item.source_value;
        n_s1.base      = (w_reg_shift && (w_op[19:16] == C_REG_PC))
                         ? i_in_item.base_value + C_PC_ADJ
                         : i_in_item.base_value;
        if (!i_in_item.req_type) begin
            n_s1.offset = w_op[25] ? w_shifted : {20'd0, w_op[11:0]};
        end else begin
            n_s1.offset = w_op[22] ? {24'd0, w_op[11:8], w_op[3:0]}
                                   : i_in_item.offset_reg_value;
        end
    end

    // ---------------- Stage 2: address arithmetic ----------------
    always_comb begin
        n_s2.half_form = r_s1.half_form;
        n_s2.load      = r_s1.load;
        n_s2.pre       = r_s1.pre;
        n_s2.wb_bit    = r_s1.wb_bit;
        n_s2.byte_bit  = r_s1.byte_bit;
        n_s2.hop       = r_s1.hop;
        n_s2.rd        = r_s1.rd;
        n_s2.rn        = r_s1.rn;
        n_s2.src       = r_s1.src;
        n_s2.mem       = r_s1.mem;
        n_s2.addr      = r_s1.up ? r_s1.base + r_s1.offset : r_s1.base - r_s1.offset;
        // Post-indexed accesses use the unmodified base.
        n_s2.eff       = r_s1.pre ? n_s2.addr : r_s1.base;
    end

    // ---------------- Stage 3: data formatting and control ----------------
    logic [31:0] w_load_val;

    lsad_load_format u_load_format (
        .i_half_form (r_s2.half_form),
        .i_is_byte   (r_s2.byte_bit),
        .i_hop       (r_s2.hop),
        .i_addr_low  (r_s2.eff[1:0]),
        .i_mem_word  (r_s2.mem),
        .o_value     (w_load_val)
    );

    always_comb begin
        logic unsup;
        logic lden;
        logic store;

        unsup = 1'b0;
        store = 1'b0;
        lden  = 1'b0;
        n_out.access_size = C_SIZE_BYTE;

        if (!r_s2.half_form) begin
            n_out.access_size = r_s2.byte_bit ? C_SIZE_BYTE : C_SIZE_WORD;
            lden  = r_s2.load;
            store = !r_s2.load;
        end else if (r_s2.load) begin
            case (r_s2.hop)
                C_HOP_UH: n_out.access_size = C_SIZE_HALF;
                C_HOP_SB: n_out.access_size = C_SIZE_BYTE;
                C_HOP_SH: n_out.access_size = C_SIZE_HALF;
                default:  unsup = 1'b1;
            endcase
            lden = !unsup;
        end else if (r_s2.hop == C_HOP_UH) begin
            n_out.access_size = C_SIZE_HALF;
            store = 1'b1;
        end else begin
            unsup = 1'b1;
        end

        n_out.access_address  = r_s2.eff;
        n_out.is_store        = store;
        n_out.store_data      = store ? r_s2.src : 32'd0;
        n_out.load_value      = lden ? w_load_val : 32'd0;
        n_out.load_enable     = lden;
        n_out.dest_index      = r_s2.rd;
        n_out.base_index      = r_s2.rn;
        // A load into the base register takes priority over the writeback.
        n_out.base_writeback  = (!r_s2.pre || r_s2.wb_bit) && !unsup
                                && !(lden && (r_s2.rn == r_s2.rd));
        n_out.base_new        = r_s2.addr;
        n_out.reload_pipeline = !r_s2.half_form && r_s2.load && (r_s2.rd == C_REG_PC);
        n_out.unsupported     = unsup;
    end

    // ---------------- Pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_s1 <= n_s1;
        end
        if (en2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (en3 && r_v2) begin
            r_out <= n_out;
        end
    end

endmodule

@@ verif/load_store_address_and_data_unit_tb.sv @@
// Self-checking testbench for the load/store address and data unit.
// Depends on lsad_pkg and load_store_address_and_data_unit, and through it on lsad_shifter and lsad_load_format.
`timescale 1ns / 1ps

module load_store_address_and_data_unit_tb;
    import lsad_pkg::*;

    localparam int RANDOM_ITEMS   = 780;
    localparam int WATCHDOG_LIMIT = 2000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_item = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // While this is set, neither side inserts idle cycles or stalls.
    bit quiet = 1'b0;

    // Decoded transfers still in flight, oldest first.
    t_out_item pending_results[$];

    // Directed table: the stimulus, and for a few rows an expectation typed in by hand.
    t_in_item  dir_stim[$];
    t_out_item dir_want[$];
    bit        dir_typed[$];

    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int stuck_cycles = 0;

    load_store_address_and_data_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Word/byte form instruction: cond, 01, I, P, U, B, W, L, Rn, Rd, low twelve bits.
    function automatic logic [31:0] wb_word(input logic i, p, u, b, w, l,
                                            input logic [3:0] rn, rd,
                                            input logic [11:0] low);
        return {4'hE, 2'b01, i, p, u, b, w, l, rn, rd, low};
    endfunction

    // Halfword/signed form instruction; the eight-bit offset is split around the SH field.
    function automatic logic [31:0] hw_word(input logic p, u, imm, w, l,
                                            input logic [3:0] rn, rd,
                                            input logic [1:0] hop,
                                            input logic [7:0] off8);
        return {4'hE, 3'b000, p, u, imm, w, l, rn, rd, off8[7:4], 1'b1, hop, 1'b1, off8[3:0]};
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] both;
        both = {v, v} >> n;
        return both[31:0];
    endfunction

    // Works out the full result of one transfer: offset, address, writeback,
    // store data and the formatted load value.
    function automatic t_out_item decode_transfer(input t_in_item s);
        t_out_item   r;
        logic [31:0] op, base, shifted, offset, addr, eff, val, src_adj, mem_sh;
        logic [15:0] lane;
        logic [7:0]  amt, pick;
        logic [4:0]  lane_sh;
        logic [3:0]  rd, rn;
        logic [1:0]  kind, size;
        logic        by_reg, is_load, wb, lden, store, reload, unsup;

        op      = s.op_word;
        base    = s.base_value;
        rd      = op[15:12];
        rn      = op[19:16];
        is_load = op[20];
        kind    = op[6:5];
        wb      = !op[24] || op[21];
        val     = '0;
        size    = C_SIZE_BYTE;
        lden    = 1'b0;
        store   = 1'b0;
        reload  = 1'b0;
        unsup   = 1'b0;
        src_adj = s.source_value + ((rd == C_REG_PC) ? C_PC_ADJ : 32'd0);

        if (!s.req_type) begin
            if (op[25]) begin
                by_reg  = op[4];
                shifted = s.offset_reg_value;
                if (by_reg) begin
                    // A register-specified shift reads the PC one word further ahead.
                    if (op[3:0] == C_REG_PC) shifted = shifted + C_PC_ADJ;
                    if (rn == C_REG_PC) base = base + C_PC_ADJ;
                    amt = s.shift_reg_value[7:0];
                end else begin
                    amt = {3'b000, op[11:7]};
                end
                if (amt == 8'd0) begin
                    // Immediate amount zero encodes LSR #32, ASR #32 and RRX.
                    if (by_reg || kind == C_SHIFT_LSL) offset = shifted;
                    else if (kind == C_SHIFT_LSR) offset = '0;
                    else if (kind == C_SHIFT_ASR) offset = {32{shifted[31]}};
                    else offset = {s.carry_in, shifted[31:1]};
                end else begin
                    case (kind)
                        C_SHIFT_LSL: offset = (amt >= 8'd32) ? '0 : shifted << amt;
                        C_SHIFT_LSR: offset = (amt >= 8'd32) ? '0 : shifted >> amt;
                        C_SHIFT_ASR: begin
                            if (amt >= 8'd32) offset = {32{shifted[31]}};
                            else offset = $signed(shifted) >>> amt;
                        end
                        default: offset = rotr32(shifted, amt[4:0]);
                    endcase
                end
            end else begin
                offset = {20'd0, op[11:0]};
            end
        end else if (op[22]) begin
            offset = {24'd0, op[11:8], op[3:0]};
        end else begin
            offset = s.offset_reg_value;
        end

        addr    = op[23] ? base + offset : base - offset;
        eff     = op[24] ? addr : base;
        lane_sh = {eff[1:0], 3'b000};
        lane    = eff[1] ? s.mem_word[31:16] : s.mem_word[15:0];
        mem_sh  = s.mem_word >> lane_sh;
        pick    = mem_sh[7:0];

        if (!s.req_type) begin
            size = op[22] ? C_SIZE_BYTE : C_SIZE_WORD;
            if (is_load) begin
                val    = op[22] ? {24'd0, pick} : rotr32(s.mem_word, lane_sh);
                lden   = 1'b1;
                reload = (rd == C_REG_PC);
            end else begin
                store = 1'b1;
            end
        end else if (is_load) begin
            case (op[6:5])
                C_HOP_UH: begin
                    size = C_SIZE_HALF;
                    val  = rotr32({16'd0, lane}, eff[0] ? 5'd8 : 5'd0);
                end
                C_HOP_SB: begin
                    size = C_SIZE_BYTE;
                    val  = {{24{pick[7]}}, pick};
                end
                C_HOP_SH: begin
                    // An odd address sign-extends just the byte it points at.
                    size = C_SIZE_HALF;
                    val  = eff[0] ? {{24{lane[15]}}, lane[15:8]} : {{16{lane[15]}}, lane};
                end
                default: unsup = 1'b1;
            endcase
            lden = !unsup;
        end else if (op[6:5] == C_HOP_UH) begin
            size  = C_SIZE_HALF;
            store = 1'b1;
        end else begin
            unsup = 1'b1;
        end

        // The loaded value wins over the base update when both target one register.
        if (unsup || (lden && rn == rd)) wb = 1'b0;

        r.access_address  = eff;
        r.access_size     = size;
        r.is_store        = store;
        r.store_data      = store ? src_adj : 32'd0;
        r.load_value      = val;
        r.load_enable     = lden;
        r.dest_index      = rd;
        r.base_index      = rn;
        r.base_writeback  = wb;
        r.base_new        = addr;
        r.reload_pipeline = reload;
        r.unsupported     = unsup;
        return r;
    endfunction

    // Random transfer. Register numbers are often made to collide or to name
    // the PC, and shift amounts and base values lean toward their edges.
    function automatic t_in_item random_transfer();
        t_in_item    s;
        logic [31:0] op;

        op = $urandom;
        if ($urandom_range(0, 3) == 0) op[15:12] = op[19:16];
        if ($urandom_range(0, 7) == 0) op[15:12] = C_REG_PC;
        if ($urandom_range(0, 7) == 0) op[19:16] = C_REG_PC;
        if ($urandom_range(0, 7) == 0) op[3:0] = C_REG_PC;
        s.req_type   = 1'($urandom_range(0, 1));
        s.op_word    = op;
        s.base_value = $urandom;
        case ($urandom_range(0, 3))
            0: s.base_value[31:8] = '1;
            1: s.base_value[31:8] = '0;
            default: ;
        endcase
        s.offset_reg_value = $urandom;
        s.shift_reg_value  = $urandom;
        case ($urandom_range(0, 4))
            0: s.shift_reg_value[7:0] = 8'd0;
            1: s.shift_reg_value[7:0] = 8'($urandom_range(1, 31));
            2: s.shift_reg_value[7:0] = 8'($urandom_range(32, 33));
            default: ;
        endcase
        s.source_value = $urandom;
        s.mem_word     = $urandom;
        s.carry_in     = 1'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic add_row(input bit typed, input t_out_item want, input logic req,
                           input logic [31:0] op, base, offr, shr, src, mem,
                           input logic carry);
        t_in_item s;
        s.req_type         = req;
        s.op_word          = op;
        s.base_value       = base;
        s.offset_reg_value = offr;
        s.shift_reg_value  = shr;
        s.source_value     = src;
        s.mem_word         = mem;
        s.carry_in         = carry;
        dir_stim.push_back(s);
        dir_want.push_back(want);
        dir_typed.push_back(typed);
    endtask

    // Offers one item, with random idle cycles ahead of it, and records the
    // expected result once the block takes it. The valid line is raised only
    // in a time step where it was not also lowered.
    task automatic drive_item(input t_in_item s, input t_out_item want);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= s;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pending_results.push_back(want);
        items_sent++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch in result %0d, %s: expected 0x%08h, got 0x%08h",
                         results_seen, name, want, got);
        end
    endtask

    // The result side stalls at random except during the quiet stretch.
    always @(posedge i_clk) begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 7);
    end

    // Every result taken is compared field by field with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %0d: address 0x%08h with nothing pending",
                             results_seen, o_out_item.access_address);
            end else begin
                want = pending_results.pop_front();
                cmp_field("access_address", want.access_address, o_out_item.access_address);
                cmp_field("access_size", 32'(want.access_size),
                          32'(o_out_item.access_size));
                cmp_field("is_store", 32'(want.is_store), 32'(o_out_item.is_store));
                cmp_field("store_data", want.store_data, o_out_item.store_data);
                cmp_field("load_value", want.load_value, o_out_item.load_value);
                cmp_field("load_enable", 32'(want.load_enable),
                          32'(o_out_item.load_enable));
                cmp_field("dest_index", 32'(want.dest_index),
                          32'(o_out_item.dest_index));
                cmp_field("base_index", 32'(want.base_index),
                          32'(o_out_item.base_index));
                cmp_field("base_writeback", 32'(want.base_writeback),
                          32'(o_out_item.base_writeback));
                cmp_field("base_new", want.base_new, o_out_item.base_new);
                cmp_field("reload_pipeline", 32'(want.reload_pipeline),
                          32'(o_out_item.reload_pipeline));
                cmp_field("unsupported", 32'(want.unsupported),
                          32'(o_out_item.unsupported));
            end
        end
    end

    // The watchdog ends the run once no item has moved on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n && ((in_valid && o_in_stall === 1'b0) ||
                        (o_out_valid === 1'b1 && !out_stall))) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        t_in_item  stim;
        t_out_item want;
        int        n;

        // All zeros: a post-indexed word store of zero, which always writes back.
        want                = '0;
        want.access_size    = C_SIZE_WORD;
        want.is_store       = 1'b1;
        want.base_writeback = 1'b1;
        add_row(1'b1, want, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);

        // A halfword-form load with the swap code is not supported: no access,
        // no data, but the address and register numbers still come out.
        want                = '0;
        want.access_address = 32'h0000_1000;
        want.base_new       = 32'h0000_1000;
        want.dest_index     = 4'd1;
        want.base_index     = 4'd2;
        want.unsupported    = 1'b1;
        add_row(1'b1, want, 1'b1, hw_word(1, 1, 1, 0, 1, 4'd2, 4'd1, C_HOP_SWP, 8'h00),
                32'h0000_1000, 32'h0, 32'h0, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0);

        // All ones in the halfword form: a signed halfword load from 0xFE, past the
        // address wrap, into the PC as its own base register, so the base is left alone.
        want                = '0;
        want.access_address = 32'h0000_00FE;
        want.access_size    = C_SIZE_HALF;
        want.load_value     = 32'hFFFF_FFFF;
        want.load_enable    = 1'b1;
        want.dest_index     = C_REG_PC;
        want.base_index     = C_REG_PC;
        want.base_new       = 32'h0000_00FE;
        add_row(1'b1, want, 1'b1, '1, '1, '1, '1, '1, '1, 1'b1);

        want = '0;
        // Unaligned word loads rotate the memory word by the byte offset.
        add_row(0, want, 0, wb_word(0, 1, 1, 0, 0, 1, 4'd2, 4'd3, 12'd1),
                32'h100, 0, 0, 0, 32'h1122_3344, 0);
        add_row(0, want, 0, wb_word(0, 1, 1, 0, 1, 1, 4'd2, 4'd3, 12'd2),
                32'h100, 0, 0, 0, 32'h1122_3344, 0);
        add_row(0, want, 0, wb_word(0, 0, 0, 0, 0, 1, 4'd2, 4'd3, 12'd4),
                32'h103, 0, 0, 0, 32'h8877_6655, 0);
        // Byte store from the PC, whose data is four ahead and wraps.
        add_row(0, want, 0, wb_word(0, 1, 1, 1, 1, 0, 4'd1, C_REG_PC, 12'hFFF),
                32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFC, 0, 0);
        add_row(0, want, 0, wb_word(0, 1, 0, 1, 0, 1, 4'd4, 4'd5, 12'hFFF),
                32'h0000_0800, 0, 0, 0, 32'hA1B2_C3D4, 0);
        // Immediate shift amount zero: LSL passes, LSR clears, ASR fills, ROR is RRX.
        add_row(0, want, 0, wb_word(1, 1, 1, 0, 0, 1, 4'd4, 4'd5,
                {5'd0, C_SHIFT_LSL, 1'b0, 4'd6}), 32'h2000, 32'h8000_0001, 0, 0, 32'h1, 0);
        add_row(0, want, 0, wb_word(1, 1, 1, 0, 0, 1, 4'd4, 4'd5,
                {5'd0, C_SHIFT_LSR, 1'b0, 4'd6}), 32'h2000, 32'hFFFF_FFFF, 0, 0, 32'h2, 0);
        add_row(0, want, 0, wb_word(1, 1, 0, 0, 0, 1, 4'd4, 4'd5,
                {5'd0, C_SHIFT_ASR, 1'b0, 4'd6}), 32'h2000, 32'h8000_0000, 0, 0, 32'h3, 0);
        add_row(0, want, 0, wb_word(1, 1, 1, 0, 0, 1, 4'd4, 4'd5,
                {5'd0, C_SHIFT_ROR, 1'b0, 4'd6}), 32'h2000, 32'h0000_0003, 0, 0, 32'h4, 1);
        add_row(0, want, 0, wb_word(1, 1, 1, 0, 0, 1, 4'd4, 4'd5,
                {5'd0, C_SHIFT_ROR, 1'b0, 4'd6}), 32'h2000, 32'h0000_0005, 0, 0, 32'h5, 0);
        // Register-specified shifts: amount 32, amount 0, beyond 32, and a ROR past 32,
        // with the PC as offset and base register in the first one.
        add_row(0, want, 0, wb_word(1, 1, 1, 0, 1, 1, C_REG_PC, 4'd7,
                {4'd8, 1'b0, C_SHIFT_LSL, 1'b1, C_REG_PC}),
                32'hFFFF_FFF0, 32'h1, 32'hFFFF_FF20, 0, 32'h6, 0);
        add_row(0, want, 0, wb_word(1, 1, 1, 0, 0, 0, 4'd4, 4'd5,
                {4'd8, 1'b0, C_SHIFT_LSR, 1'b1, 4'd6}), 32'h2000, 32'h44, 32'h100, 32'h9, 0, 0);
        add_row(0, want, 0, wb_word(1, 1, 0, 0, 0, 1, C_REG_PC, 4'd5,
                {4'd8, 1'b0, C_SHIFT_ASR, 1'b1, 4'd6}),
                32'h3000, 32'h8000_0000, 32'h28, 0, 32'h7, 0);
        add_row(0, want, 0, wb_word(1, 1, 1, 1, 0, 1, 4'd4, 4'd5,
                {4'd8, 1'b0, C_SHIFT_ROR, 1'b1, 4'd6}), 32'h2000, 32'h3, 32'h21, 0, 32'h8, 1);
        add_row(0, want, 0, wb_word(1, 0, 1, 0, 0, 1, 4'd4, 4'd5,
                {5'd31, C_SHIFT_ASR, 1'b0, 4'd6}), 32'h2000, 32'h8000_0000, 0, 0, 32'h9, 0);
        // Halfword forms: store from the PC, unaligned unsigned load, signed byte,
        // signed halfword at odd and even addresses, and an unsupported store.
        add_row(0, want, 1, hw_word(1, 1, 1, 1, 0, 4'd2, C_REG_PC, C_HOP_UH, 8'h22),
                32'h1000, 0, 0, 32'h0001_FFFE, 0, 0);
        add_row(0, want, 1, hw_word(1, 1, 1, 0, 1, 4'd2, 4'd3, C_HOP_UH, 8'h01),
                32'h1000, 0, 0, 0, 32'h80FF_7F01, 0);
        add_row(0, want, 1, hw_word(1, 1, 1, 0, 1, 4'd2, 4'd3, C_HOP_SB, 8'h03),
                32'h1000, 0, 0, 0, 32'h80FF_7F01, 0);
        add_row(0, want, 1, hw_word(1, 1, 1, 0, 1, 4'd2, 4'd3, C_HOP_SH, 8'h03),
                32'h1000, 0, 0, 0, 32'h80FF_7F01, 0);
        add_row(0, want, 1, hw_word(1, 1, 0, 1, 1, 4'd2, 4'd3, C_HOP_SH, 8'h00),
                32'h1000, 32'h2, 0, 0, 32'h80FF_7F01, 0);
        add_row(0, want, 1, hw_word(0, 0, 0, 0, 0, 4'd2, 4'd3, C_HOP_SH, 8'h00),
                32'h1000, 32'h10, 0, 32'h55, 0, 0);
        // Post-indexed load into its own base register: the load wins.
        add_row(0, want, 0, wb_word(0, 0, 1, 0, 0, 1, 4'd7, 4'd7, 12'd8),
                32'h4000, 0, 0, 0, 32'hCAFE_F00D, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < dir_stim.size(); n++)
            drive_item(dir_stim[n], dir_typed[n] ? dir_want[n] : decode_transfer(dir_stim[n]));

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 150 && n < 350);
            if (n == 500) begin
                // Hold off until the block has handed back every result.
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            stim = random_transfer();
            drive_item(stim, decode_transfer(stim));
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d load/store items (%0d from the directed table), checked %0d results.",
                 items_sent, dir_stim.size(), results_seen);
        $display("Random idle and stall on both sides, one quiet stretch, one full drain; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/lsad_pkg.sv
sv/lsad_shifter.sv
sv/lsad_load_format.sv
sv/load_store_address_and_data_unit.sv
verif/load_store_address_and_data_unit_tb.sv
